// ===== rtl/tkc_pkg.sv =====
// shared types, constants and update functions for the trivium keystream core
package tkc_pkg;

    localparam int STATE_BITS     = 288;
    localparam int SEED_BITS      = 80;
    localparam int IV_BASE        = 93;
    localparam int WARMUP_UPDATES = 4 * 288;
    localparam int STEP_BITS      = 8;
    localparam int WARM_STEPS     = WARMUP_UPDATES / STEP_BITS;
    localparam int WARM_CNT_W     = $clog2(WARM_STEPS);
    localparam logic [WARM_CNT_W-1:0] WARM_LAST = WARM_CNT_W'(WARM_STEPS - 1);
    localparam logic [2:0] TAIL_ONES = 3'h7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int HIGH_W     = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_LOW  = 3'd0;
    localparam t_cfg_idx CFG_KEY_HIGH = 3'd1;
    localparam t_cfg_idx CFG_IV_LOW   = 3'd2;
    localparam t_cfg_idx CFG_IV_HIGH  = 3'd3;

    typedef logic [STATE_BITS-1:0] t_state;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WARM,
        ST_FINISH
    } t_fsm;

    // controller to datapath
    typedef struct packed {
        logic load;    // reload state from key and iv, latch the byte
        logic advance; // eight updates, no result
        logic emit;    // eight updates and write the result register
        logic use_in;  // emit takes the byte from the input port
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a beat this cycle
    } t_status;

    typedef struct packed {
        t_state     st;
        logic [7:0] ks;
    } t_step;

    // state after key and iv load; bit i holds s[i]
    function automatic t_state load_state(input logic [SEED_BITS-1:0] key,
                                          input logic [SEED_BITS-1:0] iv);
        t_state s;
        s = '0;
        for (int n = 0; n < SEED_BITS; n++) begin
            s[n]           = key[SEED_BITS-1-n];
            s[IV_BASE + n] = iv[SEED_BITS-1-n];
        end
        s[285] = TAIL_ONES[2];
        s[286] = TAIL_ONES[1];
        s[287] = TAIL_ONES[0];
        return s;
    endfunction

    // eight updates, first keystream bit in the lsb
    function automatic t_step step8(input t_state s_in);
        t_step  r;
        t_state s;
        logic   t1;
        logic   t2;
        logic   t3;
        s = s_in;
        r.ks = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            t1 = s[65] ^ s[92];
            t2 = s[161] ^ s[176];
            t3 = s[242] ^ s[287];
            r.ks[k] = t1 ^ t2 ^ t3;
            t1 = t1 ^ (s[90] & s[91]) ^ s[170];
            t2 = t2 ^ (s[174] & s[175]) ^ s[263];
            t3 = t3 ^ (s[285] & s[286]) ^ s[68];
            s = {s[STATE_BITS-2:0], 1'b0};
            s[0]   = t3;
            s[93]  = t1;
            s[177] = t2;
        end
        r.st = s;
        return r;
    endfunction

endpackage

// ===== rtl/trivium_keystream_cipher_core.sv =====
// top level of the trivium keystream cipher core
//
//  port group   direction  handshake                 payload
//  in           to core    i_in_valid / o_in_stall   i_data_in, i_start_message
//  out          from core  o_out_valid / i_out_stall o_data_out
//  cfg          to core    i_cfg_we                  i_cfg_index, i_cfg_data
//
// for a plain data beat the eight state updates of one byte are done by one
// unrolled step8 stage, so a byte can enter every cycle while the result
// register is free; a beat with i_start_message set reloads state, runs the
// eight-update warm-up steps, then the step for its own byte: the result is
// registered after the warm-up at the earliest, later while the result
// register is held by a stalled output, input stalled meanwhile
// synchronous active-low reset clears key, iv and state; state all zero
// gives a zero keystream until the first message start
// the result register decouples the sides: a new beat is taken while the
// old result drains on the same edge
module trivium_keystream_cipher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  tkc_pkg::t_cfg_idx             i_cfg_index,
    input  logic [tkc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_in,
    input  logic                          i_start_message,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_data_out
);
    import tkc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing: acceptance, warm-up count, final byte
    tkc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_start_message (i_start_message),
        .i_status        (status),
        .o_in_stall      (o_in_stall),
        .o_cmd           (cmd)
    );

    // state, config and result storage
    tkc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data_in   (i_data_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_data_out  (o_data_out)
    );

endmodule

// ===== rtl/tkc_ctrl.sv =====
// controller: input handshake, warm-up counter and result sequencing
module tkc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_start_message,
    input  tkc_pkg::t_status  i_status,
    output logic              o_in_stall,
    output tkc_pkg::t_cmd     o_cmd
);
    import tkc_pkg::*;

    t_fsm                  r_state;
    t_fsm                  n_state;
    logic [WARM_CNT_W-1:0] r_count;
    logic [WARM_CNT_W-1:0] n_count;
    logic                  in_ready;
    logic                  accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        o_cmd    = '0;
        in_ready = 1'b0;
        accept   = 1'b0;
        case (r_state)
            ST_RUN: begin
                in_ready = i_status.out_free;
                accept   = i_in_valid && in_ready;
                if (accept) begin
                    if (i_start_message) begin
                        o_cmd.load = 1'b1;
                        n_count    = '0;
                        n_state    = ST_WARM;
                    end else begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.use_in = 1'b1;
                    end
                end
            end
            ST_WARM: begin
                o_cmd.advance = 1'b1;
                n_count       = r_count + 1'b1;
                if (r_count == WARM_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    assign o_in_stall = !in_ready;

    a_load_then_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_WARM) && (r_count == '0))
        else $error("load not followed by warm-up");

    a_warm_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WARM) && (r_count == WARM_LAST) |=> r_state == ST_FINISH)
        else $error("warm-up did not end after its last step");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((o_cmd.load && o_cmd.emit) || (o_cmd.load && o_cmd.advance)
          || (o_cmd.emit && o_cmd.advance)))
        else $error("conflicting datapath commands");

    a_stall_outside_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.advance |-> o_in_stall)
        else $error("input open during warm-up");

endmodule

// ===== rtl/tkc_datapath.sv =====
// datapath: cipher state, key and iv registers, byte latch and result register
module tkc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  tkc_pkg::t_cfg_idx             i_cfg_index,
    input  logic [tkc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                    i_data_in,
    input  tkc_pkg::t_cmd                 i_cmd,
    input  logic                          i_out_stall,
    output tkc_pkg::t_status              o_status,
    output logic                          o_out_valid,
    output logic [7:0]                    o_data_out
);
    import tkc_pkg::*;

    logic [CFG_DATA_W-1:0] r_key_low;
    logic [HIGH_W-1:0]     r_key_high;
    logic [CFG_DATA_W-1:0] r_iv_low;
    logic [HIGH_W-1:0]     r_iv_high;
    t_state                r_state;
    logic [7:0]            r_byte;
    logic                  r_out_valid;
    logic [7:0]            r_out_data;
    t_step                 step;
    logic [7:0]            src_byte;

    assign step     = step8(r_state);
    assign src_byte = i_cmd.use_in ? i_data_in : r_byte;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_low   <= '0;
            r_iv_high  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data[HIGH_W-1:0];
                CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                CFG_IV_HIGH:  r_iv_high  <= i_cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // cipher state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_cmd.load) begin
            r_state <= load_state({r_key_low, r_key_high}, {r_iv_low, r_iv_high});
        end else if (i_cmd.advance || i_cmd.emit) begin
            r_state <= step.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= src_byte ^ step.ks;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_data_out        = r_out_data;

endmodule

// ===== sim/tb_trivium_keystream_cipher_core.sv =====
// testbench for the trivium keystream cipher core
module tb_trivium_keystream_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tkc_pkg::*;

    localparam int STATE_W       = 288;
    localparam int SEED_W        = 80;
    localparam int WARM_UPDATES  = 4 * 288;
    localparam int IDLE_LIMIT    = 20000;  // cycles with no beat, no result and no register write
    localparam int SETTLE_CYCLES = 200;    // start beats get their result only after the warm-up
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 200;

    // unused register slots: one above the last register and the top index
    localparam t_cfg_idx CFG_UNUSED_FIRST = CFG_IV_HIGH + 3'd1;
    localparam t_cfg_idx CFG_UNUSED_TOP   = '1;

    // keeps its own copy of key, iv and the 288-bit state; one expected byte per beat
    class cipher_scoreboard;
        logic [63:0]        key_lo;
        logic [15:0]        key_hi;
        logic [63:0]        iv_lo;
        logic [15:0]        iv_hi;
        logic [STATE_W-1:0] s;
        logic [7:0]         expected_bytes[$];
        int                 errors;

        function new();
            key_lo = '0;
            key_hi = '0;
            iv_lo  = '0;
            iv_hi  = '0;
            s      = '0;
            errors = 0;
        endfunction

        // out-of-range indexes fall through and change nothing
        function void write_register(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_KEY_LOW:  key_lo = value;
                CFG_KEY_HIGH: key_hi = value[15:0];
                CFG_IV_LOW:   iv_lo  = value;
                CFG_IV_HIGH:  iv_hi  = value[15:0];
                default: ;
            endcase
        endfunction

        // one state update, returns the keystream bit
        function logic clock_bit();
            logic a;
            logic b;
            logic c;
            logic z;
            a = s[65] ^ s[92];
            b = s[161] ^ s[176];
            c = s[242] ^ s[287];
            z = a ^ b ^ c;
            a = a ^ (s[90] & s[91]) ^ s[170];
            b = b ^ (s[174] & s[175]) ^ s[263];
            c = c ^ (s[285] & s[286]) ^ s[68];
            s = {s[STATE_W-2:0], 1'b0};
            s[0]   = c;
            s[93]  = a;
            s[177] = b;
            return z;
        endfunction

        // key msb first into s[0..79], iv msb first into s[93..172], top three bits set, then the warm-up
        function void reload();
            logic [SEED_W-1:0] key;
            logic [SEED_W-1:0] iv;
            key = {key_lo, key_hi};
            iv  = {iv_lo, iv_hi};
            s   = '0;
            for (int n = 0; n < SEED_W; n++) begin
                s[n]      = key[SEED_W-1-n];
                s[93 + n] = iv[SEED_W-1-n];
            end
            s[287:285] = 3'b111;
            repeat (WARM_UPDATES) void'(clock_bit());
        endfunction

        function void note_input(logic [7:0] d, logic start);
            logic [7:0] ks;
            if (start) begin
                reload();
            end
            for (int k = 0; k < 8; k++) begin
                ks[k] = clock_bit();
            end
            expected_bytes.push_back(d ^ ks);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("data_out %02h with no beat outstanding", got));
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    report($sformatf("data_out %02h, expected %02h", got, want));
                end
            end
        endtask

        task leftover_check();
            if (expected_bytes.size() != 0) begin
                report($sformatf("%0d results never arrived", expected_bytes.size()));
            end
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    t_cfg_idx    cfg_index     = CFG_KEY_LOW;
    logic [63:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  data_in       = '0;
    logic        start_message = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [7:0]  data_out;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    cipher_scoreboard sb = new();

    trivium_keystream_cipher_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_in       (data_in),
        .i_start_message (start_message),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_data_out      (data_out)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stall at the rate of the current phase
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor and watchdog: everything sampled as it stood before the edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                sb.write_register(cfg_index, cfg_data);
            end
            // result first: a result can never belong to a beat taken on the same edge
            if (out_valid && !out_stall) begin
                sb.check_result(data_out);
            end
            if (in_valid && !in_stall) begin
                sb.note_input(data_in, start_message);
            end
        end
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL trivium_keystream_cipher_core");
            $finish;
        end
    end

    // one beat, with random idle cycles ahead of it; returns after the accepting edge
    task send_byte(input logic [7:0] d, input logic start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_in       <= d;
        start_message <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // sender holds off until every outstanding result has come back
    task drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // caller lowers the write enable after the last write of a batch
    task write_cfg(input t_cfg_idx idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // zero, all ones or random, leaning on the extremes
    function logic [63:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // no message started yet: zero keystream, bytes pass through
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        // message under the reset key and iv (all zero)
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        drain();

        // all-ones key and iv, upper bits of the 16-bit registers set too,
        // plus writes to unused indexes that must change nothing
        write_cfg(CFG_KEY_LOW, '1);
        write_cfg(CFG_KEY_HIGH, '1);
        write_cfg(CFG_IV_LOW, '1);
        write_cfg(CFG_IV_HIGH, '1);
        write_cfg(CFG_UNUSED_FIRST, {$urandom, $urandom});
        write_cfg(CFG_UNUSED_TOP, {$urandom, $urandom});
        cfg_we <= 1'b0;
        send_byte(8'h5A, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();

        // key and iv rewritten mid-message: running message keeps its state
        write_cfg(CFG_KEY_LOW, {$urandom, $urandom});
        write_cfg(CFG_IV_HIGH, {$urandom, $urandom});
        cfg_we <= 1'b0;
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        // new key picked up here, then two starts back to back
        send_byte(8'h00, 1'b1);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b0);

        // random phases, cycling through four idling patterns, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default: begin
                    send_idle_pct = 19;
                    stall_pct     = 19;
                end
            endcase
            drain();
            // first phase goes back to an all-zero key and iv by explicit writes
            write_cfg(CFG_KEY_LOW, (p == 0) ? 64'd0 : pick_value());
            write_cfg(CFG_KEY_HIGH, (p == 0) ? 64'd0 : pick_value());
            if (p == 0 || $urandom_range(0, 2) != 0) begin
                write_cfg(CFG_IV_LOW, (p == 0) ? 64'd0 : pick_value());
            end
            if (p == 0 || $urandom_range(0, 2) != 0) begin
                write_cfg(CFG_IV_HIGH, (p == 0) ? 64'd0 : pick_value());
            end
            if ($urandom_range(0, 1) == 0) begin
                write_cfg(t_cfg_idx'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_TOP)),
                          {$urandom, $urandom});
            end
            cfg_we <= 1'b0;

            sent = 0;
            while (sent < PHASE_BEATS) begin
                // mostly whole messages; some chunks continue without a start,
                // some are bare starts one after another
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                   : $urandom_range(3, 30);
                send_byte(8'($urandom), ($urandom_range(0, 7) != 0));
                sent++;
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom), 1'b0);
                end
                sent += len;
                if ($urandom_range(0, 15) == 0) begin
                    drain();
                end
            end
        end

        // wait for the last results, then watch for strays
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.leftover_check();
        if (sb.errors == 0) begin
            $display("PASS trivium_keystream_cipher_core");
        end else begin
            $display("FAIL trivium_keystream_cipher_core");
        end
        $finish;
    end

endmodule
